@@ rtl/hrd_pkg.sv @@
package hrd_pkg;

  localparam logic [13:0] PCT_FULL    = 14'd10000;
  localparam logic [15:0] HUE_FULL    = 16'd36000;
  localparam logic [12:0] SECTOR_SPAN = 13'd6000;
  localparam logic [16:0] ONE_Q16     = 17'h10000;

  // floor(p * 65536 / 10000) == (p * PCT_RECIP) >> PCT_SHIFT, exact for p <= 10000
  localparam logic [26:0] PCT_RECIP  = 27'd109951163;
  localparam int          PCT_SHIFT  = 24;
  // floor(n / 6000) == (n * SPAN_RECIP) >> SPAN_SHIFT, exact for n < 2**29
  localparam logic [29:0] SPAN_RECIP = 30'd733007752;
  localparam int          SPAN_SHIFT = 42;

  // hue sectors of 60 degrees each
  localparam logic [2:0] SEC_RED_YEL = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG = 3'd4;
  localparam logic [2:0] SEC_MAG_RED = 3'd5;

  // q16 channel level, 0 .. 65536
  typedef logic [16:0] lvl_t;

  typedef struct packed {
    logic        power;
    lvl_t        c;
    lvl_t        v;
    lvl_t        w;
    logic [2:0]  sector;
    logic [12:0] k;
  } chroma_t;

  typedef struct packed {
    logic power;
    lvl_t r;
    lvl_t g;
    lvl_t b;
    lvl_t w;
  } levels_t;

endpackage

@@ rtl/hrd_norm.sv @@
module hrd_norm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  output logic            stall_o,
  input  logic            power_i,
  input  logic [15:0]     hue_i,
  input  logic [13:0]     sat_i,
  input  logic [13:0]     bri_i,
  output logic            vld_o,
  input  logic            stall_i,
  output hrd_pkg::chroma_t data_o
);
  import hrd_pkg::*;

  logic        en1, en2;
  logic        s1_vld_q;
  logic        s1_pwr_q;
  lvl_t        s1_s_q, s1_v_q;
  logic [15:0] s1_hue_q;
  logic        s2_vld_q;
  chroma_t     s2_q, s2_d;

  logic [13:0] sat_c, bri_c;
  logic [40:0] s_prod, v_prod;
  logic [15:0] hue_w;
  logic [33:0] c_prod, w_prod;
  lvl_t        s_inv;
  logic [2:0]  sector;
  logic [15:0] base;
  logic [12:0] frac;

  assign en2     = !s2_vld_q || !stall_i;
  assign en1     = !s1_vld_q || en2;
  assign stall_o = !en1;

  // stage 1: clamp, percent to q16, hue wrap
  assign sat_c  = (sat_i > PCT_FULL) ? PCT_FULL : sat_i;
  assign bri_c  = (bri_i > PCT_FULL) ? PCT_FULL : bri_i;
  assign s_prod = 41'(sat_c) * 41'(PCT_RECIP);
  assign v_prod = 41'(bri_c) * 41'(PCT_RECIP);
  assign hue_w  = (hue_i >= HUE_FULL) ? hue_i - HUE_FULL : hue_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en1) begin
      s1_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_pwr_q <= power_i;
      s1_s_q   <= s_prod[PCT_SHIFT+16:PCT_SHIFT];
      s1_v_q   <= v_prod[PCT_SHIFT+16:PCT_SHIFT];
      s1_hue_q <= hue_w;
    end
  end

  // stage 2: chroma, white, sector split
  assign s_inv  = ONE_Q16 - s1_s_q;
  assign c_prod = 34'(s1_v_q) * 34'(s1_s_q);
  assign w_prod = 34'(s_inv) * 34'(s1_v_q);

  always_comb begin
    if (s1_hue_q >= 16'd30000) begin
      sector = SEC_MAG_RED;
      base   = 16'd30000;
    end else if (s1_hue_q >= 16'd24000) begin
      sector = SEC_BLU_MAG;
      base   = 16'd24000;
    end else if (s1_hue_q >= 16'd18000) begin
      sector = SEC_CYN_BLU;
      base   = 16'd18000;
    end else if (s1_hue_q >= 16'd12000) begin
      sector = SEC_GRN_CYN;
      base   = 16'd12000;
    end else if (s1_hue_q >= 16'(SECTOR_SPAN)) begin
      sector = SEC_YEL_GRN;
      base   = 16'(SECTOR_SPAN);
    end else begin
      sector = SEC_RED_YEL;
      base   = 16'd0;
    end
    frac = 13'(s1_hue_q - base);
  end

  always_comb begin
    s2_d.power  = s1_pwr_q;
    s2_d.c      = c_prod[32:16];
    s2_d.v      = s1_v_q;
    s2_d.w      = w_prod[32:16];
    s2_d.sector = sector;
    // falling edge of the sector ramp in odd sectors
    s2_d.k      = sector[0] ? SECTOR_SPAN - frac : frac;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en2) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_q <= s2_d;
    end
  end

  assign vld_o  = s2_vld_q;
  assign data_o = s2_q;

endmodule

@@ rtl/hrd_mix.sv @@
module hrd_mix (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  output logic             stall_o,
  input  hrd_pkg::chroma_t data_i,
  output logic             vld_o,
  input  logic             stall_i,
  output hrd_pkg::levels_t data_o
);
  import hrd_pkg::*;

  logic        en3, en4, en5;
  logic        s3_vld_q, s4_vld_q, s5_vld_q;
  logic        s3_pwr_q, s4_pwr_q;
  logic [2:0]  s3_sec_q, s4_sec_q;
  lvl_t        s3_c_q, s3_m_q, s3_w_q;
  lvl_t        s4_c_q, s4_m_q, s4_w_q, s4_x_q;
  logic [29:0] s3_xp_q;
  logic [59:0] x_prod;
  lvl_t        r, g, b;
  levels_t     s5_q;

  assign en5     = !s5_vld_q || !stall_i;
  assign en4     = !s4_vld_q || en5;
  assign en3     = !s3_vld_q || en4;
  assign stall_o = !en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else begin
      if (en3) s3_vld_q <= vld_i;
      if (en4) s4_vld_q <= s3_vld_q;
      if (en5) s5_vld_q <= s4_vld_q;
    end
  end

  // stage 3: c * k and the common offset m
  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_pwr_q <= data_i.power;
      s3_sec_q <= data_i.sector;
      s3_c_q   <= data_i.c;
      s3_m_q   <= data_i.v - data_i.c;
      s3_w_q   <= data_i.w;
      s3_xp_q  <= 30'(data_i.c) * 30'(data_i.k);
    end
  end

  // stage 4: divide by the sector span via reciprocal
  assign x_prod = 60'(s3_xp_q) * 60'(SPAN_RECIP);

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_pwr_q <= s3_pwr_q;
      s4_sec_q <= s3_sec_q;
      s4_c_q   <= s3_c_q;
      s4_m_q   <= s3_m_q;
      s4_w_q   <= s3_w_q;
      s4_x_q   <= x_prod[SPAN_SHIFT+16:SPAN_SHIFT];
    end
  end

  // stage 5: place c and x by sector and add the common offset m
  always_comb begin
    case (s4_sec_q)
      SEC_RED_YEL: begin r = s4_c_q; g = s4_x_q; b = '0;     end
      SEC_YEL_GRN: begin r = s4_x_q; g = s4_c_q; b = '0;     end
      SEC_GRN_CYN: begin r = '0;     g = s4_c_q; b = s4_x_q; end
      SEC_CYN_BLU: begin r = '0;     g = s4_x_q; b = s4_c_q; end
      SEC_BLU_MAG: begin r = s4_x_q; g = '0;     b = s4_c_q; end
      default:     begin r = s4_c_q; g = '0;     b = s4_x_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      s5_q.power <= s4_pwr_q;
      s5_q.r     <= r + s4_m_q;
      s5_q.g     <= g + s4_m_q;
      s5_q.b     <= b + s4_m_q;
      s5_q.w     <= s4_w_q;
    end
  end

  assign vld_o  = s5_vld_q;
  assign data_o = s5_q;

endmodule

@@ rtl/hrd_scale.sv @@
module hrd_scale (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      full_duty_i,
  input  logic             vld_i,
  output logic             stall_o,
  input  hrd_pkg::levels_t data_i,
  output logic             vld_o,
  input  logic             stall_i,
  output logic [15:0]      red_o,
  output logic [15:0]      green_o,
  output logic [15:0]      blue_o,
  output logic [15:0]      white_o
);
  import hrd_pkg::*;

  logic        en;
  logic        vld_q;
  logic [32:0] r_prod, g_prod, b_prod, w_prod;
  logic [15:0] red_q, green_q, blue_q, white_q;

  assign en      = !vld_q || !stall_i;
  assign stall_o = !en;

  assign r_prod = 33'(data_i.r) * 33'(full_duty_i);
  assign g_prod = 33'(data_i.g) * 33'(full_duty_i);
  assign b_prod = 33'(data_i.b) * 33'(full_duty_i);
  assign w_prod = 33'(data_i.w) * 33'(full_duty_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= vld_i;
    end
  end

  // power off forces every channel dark
  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q   <= data_i.power ? r_prod[31:16] : '0;
      green_q <= data_i.power ? g_prod[31:16] : '0;
      blue_q  <= data_i.power ? b_prod[31:16] : '0;
      white_q <= data_i.power ? w_prod[31:16] : '0;
    end
  end

  assign vld_o   = vld_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;
  assign white_o = white_q;

endmodule

@@ rtl/hsv_to_rgbw_duty.sv @@
// channel   direction  handshake                  payload
// cfg       in         cfg_we_i                   cfg_wdata_i (full duty)
// in        in         in_valid_i / in_stall_o    power_on_i hue_i saturation_i brightness_i
// out       out        out_valid_o / out_stall_i  red/green/blue/white_duty_o
//
// six register stages, one transaction per cycle sustained while out_stall_i is low
// stages in order: normalize, chroma, c*k, reciprocal divide, mix, scale
// each stage holds its data under stall and fills bubbles, so input keeps moving
// while the output register waits, until all six stages hold a transaction
// reset clears the valid bits and sets the full duty register to 22222
module hsv_to_rgbw_duty (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        power_on_i,
  input  logic [15:0] hue_i,
  input  logic [13:0] saturation_i,
  input  logic [13:0] brightness_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] red_duty_o,
  output logic [15:0] green_duty_o,
  output logic [15:0] blue_duty_o,
  output logic [15:0] white_duty_o
);
  import hrd_pkg::*;

  logic [15:0] full_duty_q;
  logic        norm_vld, norm_stall;
  chroma_t     norm_data;
  logic        mix_vld, mix_stall;
  levels_t     mix_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_duty_q <= 16'd22222;
    end else if (cfg_we_i) begin
      full_duty_q <= cfg_wdata_i;
    end
  end

  hrd_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (in_valid_i),
    .stall_o (in_stall_o),
    .power_i (power_on_i),
    .hue_i   (hue_i),
    .sat_i   (saturation_i),
    .bri_i   (brightness_i),
    .vld_o   (norm_vld),
    .stall_i (norm_stall),
    .data_o  (norm_data)
  );

  hrd_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (norm_vld),
    .stall_o (norm_stall),
    .data_i  (norm_data),
    .vld_o   (mix_vld),
    .stall_i (mix_stall),
    .data_o  (mix_data)
  );

  hrd_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .full_duty_i (full_duty_q),
    .vld_i       (mix_vld),
    .stall_o     (mix_stall),
    .data_i      (mix_data),
    .vld_o       (out_valid_o),
    .stall_i     (out_stall_i),
    .red_o       (red_duty_o),
    .green_o     (green_duty_o),
    .blue_o      (blue_duty_o),
    .white_o     (white_duty_o)
  );

`ifndef SYNTH
  // back pressure only comes from a full pipe behind a stalled output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_stall_i && out_valid_o))
    else $error("input stalled without a stalled output");

  a_mid_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_stall |-> (out_valid_o && out_stall_i))
    else $error("mix stage stalled while output free");

  a_power_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mix_vld && !mix_stall && !mix_data.power) |=>
      (out_valid_o && red_duty_o == '0 && green_duty_o == '0 &&
       blue_duty_o == '0 && white_duty_o == '0))
    else $error("power off transaction gave nonzero duty");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import hrd_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 380;
  localparam int NUM_PHASES    = 5;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS   = 10;
  localparam int NUM_DIRECTED  = 19;

  typedef struct packed {
    logic        power;
    logic [15:0] hue;
    logic [13:0] sat;
    logic [13:0] bright;
  } color_cmd_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] white;
  } duty_set_t;

  // known marks rows whose duties are typed in, the rest come from the predictor
  typedef struct packed {
    logic       known;
    color_cmd_t cmd;
    duty_set_t  want;
  } color_row_t;

  localparam logic [15:0] RST_DUTY = 16'd22222;

  localparam color_row_t COLOR_TABLE [NUM_DIRECTED] = '{
    '{1'b1, '{1'b0, 16'd65535, 14'd16383, 14'd16383}, '{16'd0, 16'd0, 16'd0, 16'd0}},
    '{1'b1, '{1'b1, 16'd0, 14'd0, 14'd10000}, '{RST_DUTY, RST_DUTY, RST_DUTY, RST_DUTY}},
    '{1'b1, '{1'b1, 16'd17000, 14'd7000, 14'd0}, '{16'd0, 16'd0, 16'd0, 16'd0}},
    '{1'b1, '{1'b1, 16'd0, 14'd10000, 14'd10000}, '{RST_DUTY, 16'd0, 16'd0, 16'd0}},
    '{1'b1, '{1'b1, 16'd12000, 14'd10000, 14'd10000}, '{16'd0, RST_DUTY, 16'd0, 16'd0}},
    '{1'b1, '{1'b1, 16'd24000, 14'd10000, 14'd10000}, '{16'd0, 16'd0, RST_DUTY, 16'd0}},
    '{1'b0, '{1'b1, 16'd6000, 14'd10000, 14'd10000}, '0},
    '{1'b0, '{1'b1, 16'd18000, 14'd10000, 14'd10000}, '0},
    '{1'b0, '{1'b1, 16'd30000, 14'd10000, 14'd10000}, '0},
    '{1'b0, '{1'b1, 16'd35999, 14'd10000, 14'd10000}, '0},
    '{1'b0, '{1'b1, 16'd36000, 14'd10000, 14'd10000}, '0},
    '{1'b0, '{1'b1, 16'd65535, 14'd5000, 14'd8000}, '0},
    '{1'b0, '{1'b1, 16'd5999, 14'd10001, 14'd16383}, '0},
    '{1'b0, '{1'b1, 16'd3000, 14'd16383, 14'd10000}, '0},
    '{1'b0, '{1'b1, 16'd9000, 14'd1, 14'd1}, '0},
    '{1'b0, '{1'b1, 16'd21000, 14'd5000, 14'd7500}, '0},
    '{1'b0, '{1'b1, 16'd27000, 14'd2500, 14'd10000}, '0},
    '{1'b0, '{1'b1, 16'd33000, 14'd9999, 14'd9999}, '0},
    '{1'b1, '{1'b0, 16'd0, 14'd0, 14'd0}, '{16'd0, 16'd0, 16'd0, 16'd0}}
  };

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [15:0] cfg_wdata_i  = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic        power_on_i   = 1'b0;
  logic [15:0] hue_i        = '0;
  logic [13:0] saturation_i = '0;
  logic [13:0] brightness_i = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [15:0] red_duty_o;
  logic [15:0] green_duty_o;
  logic [15:0] blue_duty_o;
  logic [15:0] white_duty_o;

  logic [15:0] full_duty_shadow = RST_DUTY;
  duty_set_t   pending_duties[$];
  int          mismatch_count  = 0;
  int          cycle_count     = 0;
  int          send_idle_pct   = 18;
  int          recv_idle_pct   = 18;

  hsv_to_rgbw_duty dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .power_on_i   (power_on_i),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_duty_o   (red_duty_o),
    .green_duty_o (green_duty_o),
    .blue_duty_o  (blue_duty_o),
    .white_duty_o (white_duty_o)
  );

  initial begin
    forever begin
      #CLK_HALF clk_i = ~clk_i;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("hsv_to_rgbw_duty regression: fail");
        $finish;
      end
    end
  end

  function automatic logic [15:0] level_to_duty(input logic [63:0] level,
                                                input logic [15:0] duty_max);
    logic [63:0] scaled;
    scaled = (level * duty_max) / ONE_Q16;
    return scaled[15:0];
  endfunction

  function automatic duty_set_t predict_duties(input color_cmd_t cmd,
                                               input logic [15:0] duty_max);
    logic [63:0] sat_c, bri_c, s_q, v_q, chroma, base, side, hue_w, span_pos;
    logic [63:0] rr, gg, bb, white;
    logic [2:0]  sector;
    duty_set_t   res;
    res = '0;
    if (cmd.power) begin
      sat_c = (cmd.sat > PCT_FULL) ? 64'(PCT_FULL) : 64'(cmd.sat);
      bri_c = (cmd.bright > PCT_FULL) ? 64'(PCT_FULL) : 64'(cmd.bright);
      s_q   = (sat_c * ONE_Q16) / PCT_FULL;
      v_q   = (bri_c * ONE_Q16) / PCT_FULL;
      hue_w = 64'(cmd.hue);
      // hue past a full turn wraps once
      if (hue_w >= HUE_FULL) begin
        hue_w = hue_w - HUE_FULL;
      end
      chroma   = (v_q * s_q) / ONE_Q16;
      base     = v_q - chroma;
      sector   = 3'(hue_w / SECTOR_SPAN);
      span_pos = hue_w % SECTOR_SPAN;
      // falling edge of the secondary color in odd sectors
      if (sector[0]) begin
        span_pos = SECTOR_SPAN - span_pos;
      end
      side = (chroma * span_pos) / SECTOR_SPAN;
      case (sector)
        SEC_RED_YEL: begin
          rr = chroma; gg = side;   bb = 0;
        end
        SEC_YEL_GRN: begin
          rr = side;   gg = chroma; bb = 0;
        end
        SEC_GRN_CYN: begin
          rr = 0;      gg = chroma; bb = side;
        end
        SEC_CYN_BLU: begin
          rr = 0;      gg = side;   bb = chroma;
        end
        SEC_BLU_MAG: begin
          rr = side;   gg = 0;      bb = chroma;
        end
        default: begin
          rr = chroma; gg = 0;      bb = side;
        end
      endcase
      white     = ((ONE_Q16 - s_q) * v_q) / ONE_Q16;
      res.red   = level_to_duty(rr + base, duty_max);
      res.green = level_to_duty(gg + base, duty_max);
      res.blue  = level_to_duty(bb + base, duty_max);
      res.white = level_to_duty(white, duty_max);
    end
    return res;
  endfunction

  function automatic logic [13:0] random_percent();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      return 14'd0;
    end else if (pick < 16) begin
      return PCT_FULL;
    end else if (pick < 28) begin
      return 14'($urandom_range(16383));
    end
    return 14'($urandom_range(10000));
  endfunction

  function automatic color_cmd_t random_color();
    color_cmd_t cmd;
    cmd.power  = ($urandom_range(99) < 88);
    cmd.hue    = ($urandom_range(99) < 80) ? 16'($urandom_range(35999))
                                           : 16'($urandom_range(65535));
    cmd.sat    = random_percent();
    cmd.bright = random_percent();
    return cmd;
  endfunction

  // called and returns on a falling edge
  task automatic send_color(input color_cmd_t cmd, input duty_set_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    power_on_i   <= cmd.power;
    hue_i        <= cmd.hue;
    saturation_i <= cmd.sat;
    brightness_i <= cmd.bright;
    do begin
      @(posedge clk_i);
    end while (in_stall_o !== 1'b0);
    pending_duties.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (pending_duties.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_full_duty(input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    full_duty_shadow = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_duties
    duty_set_t got, want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got = '{red_duty_o, green_duty_o, blue_duty_o, white_duty_o};
      if (pending_duties.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected transaction: r=%0d g=%0d b=%0d w=%0d",
                   got.red, got.green, got.blue, got.white);
        end
      end else begin
        want = pending_duties.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("duty mismatch: exp r=%0d g=%0d b=%0d w=%0d, got r=%0d g=%0d b=%0d w=%0d",
                     want.red, want.green, want.blue, want.white,
                     got.red, got.green, got.blue, got.white);
          end
        end
      end
    end
  end

  initial begin
    logic [15:0] duty_steps [NUM_PHASES];
    color_cmd_t  cmd;
    duty_steps = '{16'd65535, 16'd1, 16'd0, 16'($urandom_range(1, 65535)),
                   16'($urandom_range(1, 65535))};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (COLOR_TABLE[i]) begin
      send_color(COLOR_TABLE[i].cmd,
                 COLOR_TABLE[i].known ? COLOR_TABLE[i].want
                                      : predict_duties(COLOR_TABLE[i].cmd, full_duty_shadow));
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_pipeline();
      write_full_duty(duty_steps[p]);
      // one phase runs with both sides at full rate
      send_idle_pct = (p == 3) ? 0 : 18;
      recv_idle_pct = (p == 3) ? 0 : 18;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == PHASE_ITEMS / 2) begin
          drain_pipeline();
        end
        cmd = random_color();
        send_color(cmd, predict_duties(cmd, full_duty_shadow));
      end
    end

    drain_pipeline();
    if (mismatch_count == 0 && pending_duties.size() == 0) begin
      $display("hsv_to_rgbw_duty regression: pass");
    end else begin
      $display("hsv_to_rgbw_duty regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hrd_pkg.sv
rtl/hrd_norm.sv
rtl/hrd_mix.sv
rtl/hrd_scale.sv
rtl/hsv_to_rgbw_duty.sv
test/testbench.sv
